/* hdl/aligned_tile_run_allocator_macros.svh */
// ----------------------------------------------------------------------------
// Aligned tile run allocator assertion macros
// Concurrent property wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ALIGNED_TILE_RUN_ALLOCATOR_MACROS_SVH
`define ALIGNED_TILE_RUN_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ATRA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define ATRA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/atra_pkg.sv */
// ----------------------------------------------------------------------------
// Aligned tile run allocator package
// Beat types, operation codes and slot tag codes.
// ----------------------------------------------------------------------------
package atra_pkg;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] TAG_FREE = 2'd0;
  localparam logic [1:0] TAG_HEAD = 2'd1;
  localparam logic [1:0] TAG_CONT = 2'd2;

  localparam int TAG_W = 2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] run_length;
    logic [9:0] free_index;
  } item_t;

  typedef struct packed {
    logic [9:0] start_slot;
    logic       found;
  } result_t;

endpackage

/* hdl/atra_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module atra_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/atra_ctrl.sv */
// ----------------------------------------------------------------------------
// Aligned tile run allocator sequencer
// Walks the slot tag RAM for allocate, free, clear and the reset sweep.
// ----------------------------------------------------------------------------
module atra_ctrl #(
  parameter int NUM_SLOTS = 1024,
  parameter int MAX_RUN   = 255
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  atra_pkg::item_t              item,
  output logic                         done,
  output atra_pkg::result_t            done_res,
  input  logic                         done_take,
  output logic                         mem_we,
  output logic [$clog2(NUM_SLOTS)-1:0] mem_waddr,
  output logic [1:0]                   mem_wdata,
  output logic                         mem_re,
  output logic [$clog2(NUM_SLOTS)-1:0] mem_raddr,
  input  logic [1:0]                   mem_rdata
);

  import atra_pkg::*;

  localparam int AW = $clog2(NUM_SLOTS);
  localparam int CW = $clog2(NUM_SLOTS + 2 * MAX_RUN + 1);
  localparam int LW = $clog2(MAX_RUN + 1);

  typedef enum logic [7:0] {
    ST_INIT      = 8'b0000_0001,
    ST_IDLE      = 8'b0000_0010,
    ST_SCAN      = 8'b0000_0100,
    ST_WRITE     = 8'b0000_1000,
    ST_FREE_HEAD = 8'b0001_0000,
    ST_FREE_WALK = 8'b0010_0000,
    ST_CLEAR     = 8'b0100_0000,
    ST_RESP      = 8'b1000_0000
  } state_t;

  state_t          state, state_next;
  logic [CW-1:0]   cand, cand_next;
  logic [LW-1:0]   off, off_next;
  logic [LW-1:0]   len, len_next;
  logic            pend_valid, pend_valid_next;
  logic            pend_last, pend_last_next;
  result_t         res, res_next;

  logic [CW-1:0]   len_c;
  logic [CW-1:0]   addr_sum;
  logic [CW-1:0]   cand_inc;
  logic [CW-1:0]   cand_adv;

  assign len_c      = CW'(len);
  assign addr_sum   = cand + CW'(off);
  assign cand_inc   = cand + CW'(1);
  assign cand_adv   = cand + len_c;
  assign item_stall = (state != ST_IDLE);
  assign done       = (state == ST_RESP);
  assign done_res   = res;

  always_comb begin
    state_next      = state;
    cand_next       = cand;
    off_next        = off;
    len_next        = len;
    pend_valid_next = pend_valid;
    pend_last_next  = pend_last;
    res_next        = res;
    mem_we          = 1'b0;
    mem_waddr       = cand[AW-1:0];
    mem_wdata       = TAG_FREE;
    mem_re          = 1'b0;
    mem_raddr       = addr_sum[AW-1:0];

    case (state)
      ST_INIT, ST_CLEAR: begin
        mem_we    = 1'b1;
        cand_next = cand_inc;
        if (cand == CW'(NUM_SLOTS - 1)) begin
          res_next   = '{start_slot: '0, found: 1'b1};
          state_next = (state == ST_INIT) ? ST_IDLE : ST_RESP;
        end
      end

      ST_IDLE: begin
        if (item_valid) begin
          res_next   = '{start_slot: '0, found: 1'b0};
          state_next = ST_RESP;
          case (item.mode)
            MODE_ALLOC: begin
              if (item.run_length != 8'd0 && item.run_length <= 8'(MAX_RUN)) begin
                len_next        = LW'(item.run_length);
                cand_next       = CW'(item.run_length);
                off_next        = '0;
                pend_valid_next = 1'b0;
                if ((CW'(item.run_length) << 1) <= CW'(NUM_SLOTS)) begin
                  state_next = ST_SCAN;
                end
              end
            end
            MODE_FREE: begin
              if (32'(item.free_index) < 32'(NUM_SLOTS)) begin
                cand_next  = CW'(item.free_index);
                state_next = ST_FREE_HEAD;
              end
            end
            MODE_CLEAR: begin
              cand_next  = '0;
              state_next = ST_CLEAR;
            end
            default: begin
              state_next = ST_RESP;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (pend_valid && mem_rdata != TAG_FREE) begin
          // Occupied slot: drop the candidate, advance one run length.
          pend_valid_next = 1'b0;
          off_next        = '0;
          cand_next       = cand_adv;
          if (cand_adv + len_c > CW'(NUM_SLOTS)) begin
            state_next = ST_RESP;
          end
        end else if (pend_valid && pend_last) begin
          pend_valid_next = 1'b0;
          off_next        = '0;
          res_next        = '{start_slot: 10'(cand), found: 1'b1};
          state_next      = ST_WRITE;
        end else if (off < len) begin
          mem_re          = 1'b1;
          pend_valid_next = 1'b1;
          pend_last_next  = (off + LW'(1) == len);
          off_next        = off + LW'(1);
        end else begin
          pend_valid_next = 1'b0;
        end
      end

      ST_WRITE: begin
        mem_we    = 1'b1;
        mem_waddr = addr_sum[AW-1:0];
        mem_wdata = (off == '0) ? TAG_HEAD : TAG_CONT;
        off_next  = off + LW'(1);
        if (off + LW'(1) == len) begin
          state_next = ST_RESP;
        end
      end

      ST_FREE_HEAD: begin
        mem_we    = 1'b1;
        mem_raddr = cand_inc[AW-1:0];
        res_next  = '{start_slot: '0, found: 1'b1};
        if (cand_inc < CW'(NUM_SLOTS)) begin
          mem_re     = 1'b1;
          cand_next  = cand_inc;
          state_next = ST_FREE_WALK;
        end else begin
          state_next = ST_RESP;
        end
      end

      ST_FREE_WALK: begin
        mem_raddr = cand_inc[AW-1:0];
        if (mem_rdata == TAG_CONT) begin
          mem_we = 1'b1;
          if (cand_inc < CW'(NUM_SLOTS)) begin
            mem_re    = 1'b1;
            cand_next = cand_inc;
          end else begin
            state_next = ST_RESP;
          end
        end else begin
          state_next = ST_RESP;
        end
      end

      ST_RESP: begin
        if (done_take) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      cand       <= '0;
      off        <= '0;
      pend_valid <= 1'b0;
      pend_last  <= 1'b0;
    end else begin
      state      <= state_next;
      cand       <= cand_next;
      off        <= off_next;
      pend_valid <= pend_valid_next;
      pend_last  <= pend_last_next;
    end
  end

  always_ff @(posedge clk) begin
    len <= len_next;
    res <= res_next;
  end

endmodule

/* hdl/aligned_tile_run_allocator.sv */
// ----------------------------------------------------------------------------
// Aligned tile run allocator: first-fit aligned run allocation over a tag RAM
// Allocate reads the slots of each aligned candidate and writes back a found
// run; free clears the head and its continuations; clear sweeps all slots.
// A bad length, a run too long to fit, a free index out of range or an unused
// mode goes straight to the result. One item at a time; result stalls hold it.
// Reset: rst sweeps every tag to free, and no item is taken during the sweep.
// ----------------------------------------------------------------------------
module aligned_tile_run_allocator #(
  parameter int NUM_SLOTS = 1024,
  parameter int MAX_RUN   = 255
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  atra_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output atra_pkg::result_t result
);

  import atra_pkg::*;

  localparam int AW = $clog2(NUM_SLOTS);

  // Sequencer to RAM.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [1:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [1:0]    mem_rdata;

  // Finished result from the sequencer and the take strobe back.
  logic          done;
  result_t       done_res;
  logic          done_take;

  // The output register is free when empty or being drained this cycle, so
  // a result beat can wait downstream while the next item is taken in.
  assign done_take = !result_valid || !result_stall;

  // Sequencer: owns the allocate scan, the write-back of a found run, the
  // free walk over continuations and the clearing sweep (also run on reset).
  atra_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .MAX_RUN   (MAX_RUN)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .done       (done),
    .done_res   (done_res),
    .done_take  (done_take),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  // Slot tag store: one two-bit tag per tile slot.
  atra_ram #(
    .WIDTH (TAG_W),
    .DEPTH (NUM_SLOTS)
  ) u_tags (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: load a finished result, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (done && done_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Payload: hold while stalled, no reset needed.
  always_ff @(posedge clk) begin
    if (done && done_take) begin
      result <= done_res;
    end
  end

endmodule

/* hdl/atra_checker.sv */
// ----------------------------------------------------------------------------
// Aligned tile run allocator port checker
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`include "aligned_tile_run_allocator_macros.svh"

module atra_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input atra_pkg::result_t result
);

  import atra_pkg::*;

  `ATRA_ASSERT_SAME(a_fail_zero_start, result_valid && !result.found, result.start_slot == 10'd0, "failed result carries a nonzero start slot")
  `ATRA_ASSERT_NEXT(a_busy_after_accept, item_valid && !item_stall, item_stall, "item accepted while previous item still in work")
  `ATRA_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result), "stalled result beat changed")
  `ATRA_ASSERT_SAME(a_valid_drop, $fell(result_valid), $past(!result_stall), "result beat dropped without being taken")

endmodule

bind aligned_tile_run_allocator atra_checker u_atra_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
